### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property violated");

// Boolean condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`endif

### hw/rtl/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Types, constants and step functions of the resize scale factor unit.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int SizeBits        = 12;
  localparam int FracBits        = 12;
  localparam int ScaleBits       = 16;
  localparam int IntBits         = ScaleBits - FracBits;
  localparam int PbBits          = 16;
  localparam int PbQuotBits      = 7;
  localparam int DivBitsPerStage = 4;
  localparam int NumDivStages    = ScaleBits / DivBitsPerStage;
  localparam int PbStepsFirst    = 4;
  localparam int PbStepsLast     = PbQuotBits - PbStepsFirst;

  localparam int DataWidth  = 32;
  localparam int PaddrWidth = 3;

  // Word index of the register on paddr[PaddrWidth-1]
  localparam logic RegOlderVariant = 1'b0;

  localparam logic [ScaleBits-1:0] OneFix    = ScaleBits'(4096);
  localparam logic [ScaleBits-1:0] SnapMask  = ScaleBits'(16'h0007);
  localparam logic [ScaleBits-1:0] SnapStep  = ScaleBits'(8);
  localparam logic [PbBits-1:0]    PbUnity   = PbBits'(64);
  localparam logic [IntBits-1:0]   MantK4    = IntBits'(8);
  localparam logic [IntBits-1:0]   MantK2    = IntBits'(4);
  // 64 * 4096 with the low PbQuotBits dividend bits taken off
  localparam logic [ScaleBits-1:0] PbRemBase = ScaleBits'((64 * 4096) >> PbQuotBits);

  typedef struct packed {
    logic [SizeBits-1:0] source_size;
    logic [SizeBits-1:0] dest_size;
  } in_t;

  typedef struct packed {
    logic [ScaleBits-1:0] scale_word;
    logic [PbBits-1:0]    passband_word;
    logic                 passband_valid;
    logic                 error;
  } out_t;

  typedef struct packed {
    logic                 older;
    logic                 err_pre;
    logic                 eq;
    logic                 enlarge;
    logic                 shrink;
    logic                 ovf;
    logic [SizeBits-1:0]  d;
    logic [SizeBits-1:0]  rem;
    logic [ScaleBits-1:0] num;
    logic [ScaleBits-1:0] quo;
  } div_stage_t;

  typedef struct packed {
    logic                  older;
    logic                  err;
    logic                  shrink;
    logic [ScaleBits-1:0]  ratio;
    logic [ScaleBits-1:0]  rem;
    logic [PbQuotBits-1:0] quo;
  } pb_stage_t;

  // One restoring step of the scale ratio division.
  function automatic div_stage_t div_iter(div_stage_t s);
    logic [SizeBits:0] t;
    div_stage_t        r;
    r = s;
    t = {s.rem, s.num[ScaleBits-1]};
    if (t >= {1'b0, s.d}) begin
      r.rem = SizeBits'(t - {1'b0, s.d});
      r.quo = {s.quo[ScaleBits-2:0], 1'b1};
    end else begin
      r.rem = t[SizeBits-1:0];
      r.quo = {s.quo[ScaleBits-2:0], 1'b0};
    end
    r.num = {s.num[ScaleBits-2:0], 1'b0};
    return r;
  endfunction

  // One restoring step of the passband division; remaining dividend bits are zero.
  function automatic pb_stage_t pb_iter(pb_stage_t s);
    logic [ScaleBits:0] t;
    pb_stage_t          r;
    r = s;
    t = {s.rem, 1'b0};
    if (t >= {1'b0, s.ratio}) begin
      r.rem = ScaleBits'(t - {1'b0, s.ratio});
      r.quo = {s.quo[PbQuotBits-2:0], 1'b1};
    end else begin
      r.rem = t[ScaleBits-1:0];
      r.quo = {s.quo[PbQuotBits-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### hw/rtl/resize_scale_factor_calc_unit.sv
// ----------------------------------------------------------------------------
// resize_scale_factor_calc_unit
// Scale word and passband word of the video resizer for one axis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries a source and
//   destination size pair; output channel (out_valid_o / out_stall_i /
//   out_data_o) returns one result transaction per input transaction.
//   The APB port holds older_variant at byte address 0; write it only while
//   no transaction is in flight.
//   Throughput: one transaction per cycle while the output is not stalled.
//   Stages from acceptance to out_valid_o, in order: one for operand setup;
//   4 for the ratio divider, which makes 16 quotient bits, 4 per stage; one
//   for snapping; 2 for the passband divider, which makes 7 bits.
//   Reset clears all valid bits and selects the newer variant.
//   A stalled output holds its transaction and freezes the pipeline; a
//   one-entry skid buffer at the input takes one more transaction, then
//   in_stall_o rises in the next cycle until the pipeline moves again.
// ----------------------------------------------------------------------------
module resize_scale_factor_calc_unit import rsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0]  pwdata,
  output logic [DataWidth-1:0]  prdata,
  output logic                  pready
);

  logic older_q;

  logic skid_valid_q, skid_valid_d;
  in_t  skid_q;

  logic [NumDivStages:0] div_v_q;
  div_stage_t            div_q [0:NumDivStages];
  div_stage_t            div_d [0:NumDivStages];

  logic      b_v_q, c_v_q, out_valid_q;
  pb_stage_t b_q, b_d, c_q, c_d;
  out_t      out_q, out_d;

  logic en, in_acc, a_valid;
  in_t  a_in;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = (paddr[PaddrWidth-1] == RegOlderVariant) ?
                  {{(DataWidth-1){1'b0}}, older_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PaddrWidth-1] == RegOlderVariant) begin
      older_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- control
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign a_valid     = skid_valid_q || in_valid_i;
  assign a_in        = skid_valid_q ? skid_q : in_data_i;
  assign skid_valid_d = en ? 1'b0 : (skid_valid_q || in_acc);

  // ---------------------------------------------------------------- operand setup
  logic [SizeBits-1:0]          src_m1, dst_m1;
  logic [SizeBits+FracBits-1:0] dividend;
  logic                         zero_size, same_size;

  always_comb begin
    src_m1    = a_in.source_size - SizeBits'(1);
    dst_m1    = a_in.dest_size - SizeBits'(1);
    dividend  = {src_m1, {FracBits{1'b0}}};
    zero_size = (a_in.source_size == '0) || (a_in.dest_size == '0);
    same_size = (a_in.source_size == a_in.dest_size);

    div_d[0].older   = older_q;
    div_d[0].err_pre = zero_size || (a_in.dest_size == SizeBits'(1) && !same_size);
    div_d[0].eq      = same_size;
    div_d[0].enlarge = a_in.dest_size > a_in.source_size;
    div_d[0].shrink  = a_in.source_size > a_in.dest_size;
    div_d[0].d       = dst_m1;
    div_d[0].rem     = SizeBits'(dividend >> ScaleBits);
    // quotient would not fit in the scale word
    div_d[0].ovf     = SizeBits'(dividend >> ScaleBits) >= dst_m1;
    div_d[0].num     = dividend[ScaleBits-1:0];
    div_d[0].quo     = '0;
  end

  // ---------------------------------------------------------------- ratio divider
  for (genvar g = 0; g < NumDivStages; g++) begin : g_div
    always_comb begin
      div_stage_t s;
      s = div_q[g];
      for (int k = 0; k < DivBitsPerStage; k++) begin
        s = div_iter(s);
      end
      div_d[g+1] = s;
    end
  end

  // ---------------------------------------------------------------- snap, range check
  div_stage_t           last;
  logic [ScaleBits-1:0] raw, base;
  logic [ScaleBits:0]   ratio_w;
  logic [IntBits-1:0]   mant;

  always_comb begin
    last = div_q[NumDivStages];
    raw  = last.quo;
    base = raw & ~SnapMask;
    priority if (last.eq) begin
      ratio_w = {1'b0, OneFix};
    end else if (last.older && (raw & SnapMask) != '0) begin
      if (last.enlarge) begin
        ratio_w = (base >= SnapStep) ? {1'b0, base - SnapStep} : '0;
      end else begin
        ratio_w = {1'b0, base} + {1'b0, SnapStep};
      end
    end else begin
      ratio_w = {1'b0, raw};
    end
    mant = ratio_w[ScaleBits-1:FracBits];

    b_d.older  = last.older;
    b_d.err    = last.err_pre || (!last.eq && (last.ovf || ratio_w[ScaleBits]));
    b_d.shrink = last.shrink;
    b_d.ratio  = ratio_w[ScaleBits-1:0];
    b_d.quo    = '0;
    priority if (mant >= MantK4) begin
      b_d.rem = PbRemBase << 2;
    end else if (mant >= MantK2) begin
      b_d.rem = PbRemBase << 1;
    end else begin
      b_d.rem = PbRemBase;
    end
  end

  // ---------------------------------------------------------------- passband divider
  always_comb begin
    c_d = b_q;
    for (int k = 0; k < PbStepsFirst; k++) begin
      c_d = pb_iter(c_d);
    end
  end

  pb_stage_t p;

  always_comb begin
    p = c_q;
    for (int k = 0; k < PbStepsLast; k++) begin
      p = pb_iter(p);
    end
    if (p.err) begin
      out_d.scale_word     = '0;
      out_d.passband_word  = '0;
      out_d.passband_valid = 1'b0;
      out_d.error          = 1'b1;
    end else begin
      out_d.scale_word = p.ratio;
      if (p.older) begin
        out_d.passband_word = '0;
      end else if (!p.shrink) begin
        out_d.passband_word = PbUnity;
      end else if (p.ratio != '0) begin
        out_d.passband_word = PbBits'(p.quo);
      end else begin
        out_d.passband_word = '0;
      end
      out_d.passband_valid = !p.older;
      out_d.error          = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      div_v_q      <= '0;
      b_v_q        <= 1'b0;
      c_v_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
      if (en) begin
        div_v_q     <= {div_v_q[NumDivStages-1:0], a_valid};
        b_v_q       <= div_v_q[NumDivStages];
        c_v_q       <= b_v_q;
        out_valid_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !en) begin
      skid_q <= in_data_i;
    end
    if (en) begin
      for (int i = 0; i <= NumDivStages; i++) begin
        div_q[i] <= div_d[i];
      end
      b_q   <= b_d;
      c_q   <= c_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/rsf_checker.sv
// ----------------------------------------------------------------------------
// rsf_checker
// Port-level assertions for the resize scale factor unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsf_checker import rsf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // stalled result transaction holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // error result carries no scale or passband
  `ASSERT_NEVER(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.error && (out_data_o.scale_word != '0 || out_data_o.passband_word != '0 || out_data_o.passband_valid))

  // passband word is never zero and never above unity
  `ASSERT_CLK(a_pb_range, clk_i, rst_ni, out_valid_o && out_data_o.passband_valid |-> out_data_o.passband_word != '0 && out_data_o.passband_word <= PbUnity)

  // input side only backs up after the output was stalled
  `ASSERT_CLK(a_in_stall_cause, clk_i, rst_ni, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))

endmodule

bind resize_scale_factor_calc_unit rsf_checker u_rsf_checker (.*);

### tb/resize_scale_factor_calc_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resize_scale_factor_calc_unit_tb
// Drives size pairs into the scale factor unit under both variants, predicts
// the scale and passband words per transaction, and checks every result in
// order. Random input idles and output stalls, plus a long output stall.
// ----------------------------------------------------------------------------
module resize_scale_factor_calc_unit_tb;
  import rsf_pkg::*;

  localparam int unsigned MaxSize       = (1 << SizeBits) - 1;
  localparam int unsigned UnityRatio    = 4096;
  localparam int unsigned SnapLowBits   = 32'h7;
  localparam int unsigned SnapStep      = 8;
  localparam int unsigned PassbandUnity = 64;
  localparam int unsigned MaxIntPart    = 15;
  localparam int unsigned IntPartK4     = 8;
  localparam int unsigned IntPartK2     = 4;
  localparam int unsigned MismatchShown = 10;
  localparam int unsigned LongHoldCycles = 300;
  localparam logic [PaddrWidth-1:0] OlderVariantAddr = PaddrWidth'({RegOlderVariant, 2'b00});

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PaddrWidth-1:0] paddr       = '0;
  logic [DataWidth-1:0]  pwdata      = '0;
  logic [DataWidth-1:0]  prdata;
  logic                  pready;

  resize_scale_factor_calc_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Scale word, passband word and flags for one size pair.
  function automatic out_t calc_scale_factor(logic older, in_t sizes);
    int unsigned src;
    int unsigned dst;
    int unsigned ratio;
    int unsigned int_part;
    int unsigned k;
    int unsigned pb;
    logic        err;
    out_t        r;
    src   = sizes.source_size;
    dst   = sizes.dest_size;
    ratio = 0;
    pb    = 0;
    err   = 1'b0;
    if (src == 0 || dst == 0) begin
      err = 1'b1;
    end else if (src == dst) begin
      ratio = UnityRatio;
    end else if (dst == 1) begin
      err = 1'b1;
    end else begin
      ratio = (UnityRatio * (src - 1)) / (dst - 1);
      if (older && (ratio & SnapLowBits) != 0) begin
        ratio = ratio & ~SnapLowBits;
        // round down when enlarging (floor at zero), up when shrinking
        if (dst > src) begin
          ratio = (ratio >= SnapStep) ? ratio - SnapStep : 0;
        end else begin
          ratio = ratio + SnapStep;
        end
      end
    end
    int_part = ratio / UnityRatio;
    if (!err && int_part > MaxIntPart) err = 1'b1;
    if (!err && !older) begin
      if (dst >= src) begin
        pb = PassbandUnity;
      end else begin
        if (int_part >= IntPartK4) k = 4;
        else if (int_part >= IntPartK2) k = 2;
        else k = 1;
        pb = (ratio != 0) ? (PassbandUnity * UnityRatio * k) / ratio : 0;
      end
    end
    if (err) begin
      r = '0;
      r.error = 1'b1;
    end else begin
      r.scale_word     = ScaleBits'(ratio);
      r.passband_word  = PbBits'(pb);
      r.passband_valid = !older;
      r.error          = 1'b0;
    end
    return r;
  endfunction

  class scale_scoreboard;
    out_t        results_due[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function void note_input(in_t sizes, logic older);
      results_due.push_back(calc_scale_factor(older, sizes));
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function void log_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      if (mismatch_count <= MismatchShown) begin
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (results_due.size() == 0) begin
        log_mismatch("unexpected result, scale_word", 0, got.scale_word);
        return;
      end
      want = results_due.pop_front();
      if (got.scale_word !== want.scale_word)
        log_mismatch("scale_word", want.scale_word, got.scale_word);
      if (got.passband_word !== want.passband_word)
        log_mismatch("passband_word", want.passband_word, got.passband_word);
      if (got.passband_valid !== want.passband_valid)
        log_mismatch("passband_valid", want.passband_valid, got.passband_valid);
      if (got.error !== want.error)
        log_mismatch("error", want.error, got.error);
    endfunction
  endclass

  scale_scoreboard sb;
  logic            older_mode   = 1'b0;
  bit              src_idle_en  = 1'b0;
  bit              sink_idle_en = 1'b0;
  int unsigned     sink_hold    = 0;
  int unsigned     stall_left   = 0;

  // Output stall: a long hold on request, else random bursts.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_stall_i <= 1'b1;
      sink_hold   = sink_hold - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  = $urandom_range(1, 10) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic in_t size_pair(int unsigned src, int unsigned dst);
    in_t p;
    p.source_size = SizeBits'(src);
    p.dest_size   = SizeBits'(dst);
    return p;
  endfunction

  // Mostly legal enlarge/shrink pairs; some raw noise and corner pairs.
  function automatic in_t random_size_pair();
    int unsigned sel;
    int unsigned src;
    int unsigned dst;
    int unsigned hi;
    sel = $urandom_range(0, 15);
    if (sel < 2) begin
      src = $urandom_range(0, MaxSize);
      dst = $urandom_range(0, MaxSize);
    end else if (sel < 8) begin
      dst = $urandom_range(2, MaxSize);
      hi  = 16 * (dst - 1) + 1;
      if (hi > MaxSize) hi = MaxSize;
      src = $urandom_range(dst, hi);
    end else if (sel < 14) begin
      src = $urandom_range(1, MaxSize);
      dst = $urandom_range(src, MaxSize);
    end else begin
      src = $urandom_range(0, MaxSize);
      dst = $urandom_range(0, MaxSize);
      case ($urandom_range(0, 3))
        0: dst = src;
        1: dst = 1;
        2: src = 0;
        default: dst = 0;
      endcase
    end
    return size_pair(src, dst);
  endfunction

  task automatic send_item(in_t sizes);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= sizes;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(sizes, older_mode);
  endtask

  task automatic maybe_idle_input();
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) begin
      maybe_idle_input();
      send_item(random_size_pair());
    end
  endtask

  task automatic run_directed();
    send_item(size_pair(1, 1));
    send_item(size_pair(MaxSize, MaxSize));
    send_item(size_pair(0, MaxSize));
    send_item(size_pair(MaxSize, 0));
    send_item(size_pair(0, 0));
    send_item(size_pair(7, 1));          // zero divisor
    send_item(size_pair(MaxSize, 2));    // far above 16.0
    send_item(size_pair(17, 2));         // exactly 16.0
    send_item(size_pair(16, 2));         // 15.0
    send_item(size_pair(1, MaxSize));    // enlarge, ratio zero
    send_item(size_pair(2, MaxSize));    // enlarge snap floors at zero
    send_item(size_pair(4094, 2048));    // shrink snap carries into integer part
    send_item(size_pair(500, 100));      // mid passband scale
    send_item(size_pair(1000, 100));     // top passband scale
  endtask

  // Write the register, then read it back.
  task automatic set_older_variant(logic value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OlderVariantAddr;
    pwdata  <= DataWidth'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    older_mode = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataWidth'(value)) sb.log_mismatch("older_variant readback", value, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    drain_results();
    set_older_variant(1'b1);
    run_directed();
    drain_results();

    set_older_variant(1'b0);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_random(100);
    drain_results();
    send_random(100);
    drain_results();

    set_older_variant(1'b1);
    send_random(50);
    // hold the output while the input keeps offering, so the pipe backs up
    sink_hold = LongHoldCycles;
    send_random(150);
    drain_results();

    set_older_variant(1'b0);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random(200);
    drain_results();

    repeat (20) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("resize_scale_factor_calc_unit_tb: clean");
    end else begin
      $display("resize_scale_factor_calc_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("resize_scale_factor_calc_unit_tb: errors");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rsf_pkg.sv
hw/rtl/resize_scale_factor_calc_unit.sv
hw/rtl/rsf_checker.sv
tb/resize_scale_factor_calc_unit_tb.sv
